// ===== rtl/core/fbs_pkg.sv =====
// shared types and constants for the frequency batch statistics block
`default_nettype none

package fbs_pkg;

   localparam int FREQ_W        = 17;
   localparam int IDX_W         = 8;
   localparam int COUNT_OUT_W   = 11;
   localparam int CSR_DATA_W    = 17;
   localparam int CSR_INDEX_W   = 1;

   localparam int SIGNAL_COUNT_DEF = 256;
   localparam int MAX_BATCH_DEF    = 1024;

   localparam logic [FREQ_W-1:0] LOW_LIMIT_RST  = FREQ_W'(57000);
   localparam logic [FREQ_W-1:0] HIGH_LIMIT_RST = FREQ_W'(62000);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOW_LIMIT  = 1'b0,
      CSR_HIGH_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // one entry of the last-value table: seen mark plus last stored value
   typedef struct packed {
      logic              seen;
      logic [FREQ_W-1:0] value;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/frequency_batch_stats_flatline.sv =====
// top level of the frequency batch statistics block with flat-line rejection
`default_nettype none

// Frequency samples in millihertz arrive one word at a time, each tagged with a
// signal index. A sample equal to the last value stored for its signal is
// dropped as flat-lined, and a sample must lie strictly between the low and high
// limit registers to count. Counted samples feed the batch sum, count, max and
// min; the word that carries batch_end produces one response word with the
// truncated mean, max, min and count (all zero, has_data low, for an empty
// batch) and then clears the batch. Each word is accepted while the last-value
// memory is read, then compared and, unless flat-lined, its entry written back in
// the lookup state. A batch-end word that has data then runs the bit-serial divider
// for the 17-bit quotient before the response register is loaded; an empty batch
// goes straight to the load. The load also waits while a previous response word
// sits stalled in the response register. After reset the last-value memory is
// swept clean, one entry a cycle, and req_stall stays high until the sweep is done.
// Limit registers may be written at any time the block is idle and take effect
// from the next word.
module frequency_batch_stats_flatline
   import fbs_pkg::*;
#(
   parameter int SIGNAL_COUNT = SIGNAL_COUNT_DEF,
   parameter int MAX_BATCH    = MAX_BATCH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration writes
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data,
   // sample words
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [IDX_W-1:0]       req_signal_index,
   input  wire logic [FREQ_W-1:0]      req_freq_mhz,
   input  wire logic                   req_batch_end,
   // batch result words
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic                   rsp_has_data,
   output      logic [FREQ_W-1:0]      rsp_avg_mhz,
   output      logic [FREQ_W-1:0]      rsp_max_mhz,
   output      logic [FREQ_W-1:0]      rsp_min_mhz,
   output      logic [COUNT_OUT_W-1:0] rsp_accepted_count
);

   localparam int ADDR_W = $clog2(SIGNAL_COUNT);
   localparam int CNT_W  = $clog2(MAX_BATCH + 1);
   localparam int SUM_W  = FREQ_W + CNT_W;

   // limit registers
   logic [FREQ_W-1:0] low_limit_ff;
   logic [FREQ_W-1:0] high_limit_ff;

   // control
   state_type         state_ff;
   state_type         state_in;
   logic              req_accept;
   logic              rsp_load;

   // captured sample word
   logic [IDX_W-1:0]  idx_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic              end_ff;

   // batch accumulators
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [FREQ_W-1:0] max_ff;
   logic [FREQ_W-1:0] max_in;
   logic [FREQ_W-1:0] min_ff;
   logic [FREQ_W-1:0] min_in;

   // lookup stage
   logic              in_range;
   logic              flat;
   logic              take;
   entry_type         tbl_rd_data;
   entry_type         tbl_wr_data;
   logic              tbl_wr_en;
   logic              tbl_ready;

   // divider
   logic              div_start;
   logic              div_done;
   logic [FREQ_W-1:0] div_quot;

   // response register
   logic                   rsp_valid_ff;
   logic                   rsp_has_data_ff;
   logic [FREQ_W-1:0]      rsp_avg_ff;
   logic [FREQ_W-1:0]      rsp_max_ff;
   logic [FREQ_W-1:0]      rsp_min_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic                   has_data;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff  <= LOW_LIMIT_RST;
         high_limit_ff <= HIGH_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_LOW_LIMIT:  low_limit_ff  <= csr_wr_data;
            CSR_HIGH_LIMIT: high_limit_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- intake
   // one word in flight; wait for the memory sweep after reset
   assign req_stall  = !((state_ff == ST_IDLE) && tbl_ready);
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         idx_ff  <= req_signal_index;
         freq_ff <= req_freq_mhz;
         end_ff  <= req_batch_end;
      end
   end

   // ---------------------------------------------------------------- last-value memory
   fbs_last_table #(
      .SIGNAL_COUNT(SIGNAL_COUNT)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (ADDR_W'(req_signal_index)),
      .rd_data (tbl_rd_data),
      .wr_en   (tbl_wr_en),
      .wr_addr (ADDR_W'(idx_ff)),
      .wr_data (tbl_wr_data),
      .ready   (tbl_ready)
   );

   // indexes past the table skip the flat-line check and are not stored
   assign in_range = 32'(idx_ff) < 32'(SIGNAL_COUNT);
   assign flat     = in_range && tbl_rd_data.seen && (tbl_rd_data.value == freq_ff);
   // write back the new value and the seen mark on anything not flat-lined
   assign tbl_wr_en   = (state_ff == ST_LOOKUP) && in_range && !flat;
   assign tbl_wr_data = '{seen: 1'b1, value: freq_ff};

   // sample counts when not flat, inside the limits and the batch has room
   assign take = !flat && (freq_ff > low_limit_ff) && (freq_ff < high_limit_ff)
                 && (32'(count_ff) < 32'(MAX_BATCH));

   // ---------------------------------------------------------------- accumulators
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      if ((state_ff == ST_LOOKUP) && take) begin
         sum_in   = sum_ff + SUM_W'(freq_ff);
         count_in = count_ff + CNT_W'(1);
         // first counted sample loads the extremes directly
         if (count_ff == '0) begin
            max_in = freq_ff;
            min_in = freq_ff;
         end else begin
            if (freq_ff > max_ff) begin
               max_in = freq_ff;
            end
            if (freq_ff < min_ff) begin
               min_in = freq_ff;
            end
         end
      end else if (rsp_load) begin
         sum_in   = '0;
         count_in = '0;
         max_in   = low_limit_ff;
         min_in   = high_limit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         max_ff   <= LOW_LIMIT_RST;
         min_ff   <= HIGH_LIMIT_RST;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
      end
   end

   // ---------------------------------------------------------------- mean
   // start on the updated totals so the divide begins in the lookup cycle
   assign div_start = (state_ff == ST_LOOKUP) && end_ff && (count_in != '0);

   fbs_divider #(
      .CNT_W(CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (count_in),
      .quotient (div_quot),
      .done     (div_done)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (!end_ff) begin
               state_in = ST_IDLE;
            end else if (div_start) begin
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // load once the response register is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- response register
   assign has_data = count_ff != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_has_data_ff <= has_data;
         rsp_avg_ff      <= has_data ? div_quot : '0;
         rsp_max_ff      <= has_data ? max_ff : '0;
         rsp_min_ff      <= has_data ? min_ff : '0;
         rsp_count_ff    <= COUNT_OUT_W'(count_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_has_data       = rsp_has_data_ff;
   assign rsp_avg_mhz        = rsp_avg_ff;
   assign rsp_max_mhz        = rsp_max_ff;
   assign rsp_min_mhz        = rsp_min_ff;
   assign rsp_accepted_count = rsp_count_ff;

`ifndef SYNTHESIS
   // an accepted word always goes straight to the lookup cycle
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted word did not enter lookup");

   // the batch count never passes its limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_BATCH))
      else $error("batch count beyond limit");

   // a response appears only out of the finish cycle
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response loaded outside finish");

   // nothing is taken while the memory sweep runs
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      !tbl_ready |-> req_stall)
      else $error("word accepted during memory sweep");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/fbs_last_table.sv =====
// last-value table memory with seen marks and the clearing pass after reset
`default_nettype none

module fbs_last_table
   import fbs_pkg::*;
#(
   parameter int SIGNAL_COUNT = SIGNAL_COUNT_DEF,
   localparam int ADDR_W      = $clog2(SIGNAL_COUNT)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      entry_type         rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire entry_type         wr_data,
   output      logic              ready
);

   entry_type         mem [SIGNAL_COUNT];
   entry_type         rd_data_ff;
   logic              clear_ff;
   logic              clear_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   entry_type         mem_wdata;

   // sweep one entry a cycle until the last one is cleared
   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(SIGNAL_COUNT - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_comb begin
      if (clear_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = wr_en;
         mem_waddr = wr_addr;
         mem_wdata = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clear_ff;

endmodule

`default_nettype wire

// ===== rtl/core/fbs_divider.sv =====
// restoring divider, one quotient bit a cycle, for the batch mean
`default_nettype none

module fbs_divider
   import fbs_pkg::*;
#(
   parameter int CNT_W  = 11,
   localparam int SUM_W = FREQ_W + CNT_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SUM_W-1:0]  dividend,
   input  wire logic [CNT_W-1:0]  divisor,
   output      logic [FREQ_W-1:0] quotient,
   output      logic              done
);

   localparam int STEP_W = $clog2(FREQ_W + 1);

   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  rem_in;
   logic [FREQ_W-1:0] low_ff;
   logic [FREQ_W-1:0] low_in;
   logic [CNT_W-1:0]  div_ff;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              busy_ff;
   logic              busy_in;
   logic              done_ff;
   logic              done_in;
   logic [CNT_W:0]    trial;
   logic              ge;

   // quotient fits in FREQ_W bits since the mean never exceeds the largest sample,
   // so the upper dividend bits start out below the divisor
   always_comb begin
      trial   = {rem_ff, low_ff[FREQ_W-1]};
      ge      = trial >= {1'b0, div_ff};
      rem_in  = rem_ff;
      low_in  = low_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[SUM_W-1:FREQ_W];
         low_in  = dividend[FREQ_W-1:0];
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? CNT_W'(trial - {1'b0, div_ff}) : trial[CNT_W-1:0];
         low_in  = {low_ff[FREQ_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(FREQ_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      step_ff <= step_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign quotient = low_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== verif/frequency_batch_stats_flatline_tb.sv =====
// self-checking testbench for the frequency batch statistics block with flat-line rejection
`default_nettype none

module frequency_batch_stats_flatline_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fbs_pkg::*;

   localparam int CLK_PERIOD       = 10;
   localparam int RESET_CYCLES     = 7;
   // margin that covers a batch-end word with data still in flight, divider included
   localparam int SETTLE_CYCLES    = 40;
   // long receiver hold-off so the result register fills and the block backs up
   localparam int HOLD_CYCLES      = 400;
   localparam int HOLD_AFTER       = 120;
   // quiet-cycle budget: memory sweep, hold-off and slow stalls, several times over
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int RANDOM_WORDS     = 72;
   localparam int RANDOM_PHASES    = 6;
   localparam logic [FREQ_W-1:0] FREQ_TOP = '1;

   typedef struct packed {
      logic [IDX_W-1:0]  signal_index;
      logic [FREQ_W-1:0] freq_mhz;
      logic              batch_end;
   } sample_word_type;

   typedef struct packed {
      logic                   has_data;
      logic [FREQ_W-1:0]      avg_mhz;
      logic [FREQ_W-1:0]      max_mhz;
      logic [FREQ_W-1:0]      min_mhz;
      logic [COUNT_OUT_W-1:0] accepted_count;
   } batch_summary_type;

   // clock, reset and block ports; every input starts at a known value
   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   csr_wr_en          = 1'b0;
   csr_index_type          csr_index          = CSR_LOW_LIMIT;
   logic [CSR_DATA_W-1:0]  csr_wr_data        = '0;
   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic [IDX_W-1:0]       req_signal_index   = '0;
   logic [FREQ_W-1:0]      req_freq_mhz       = '0;
   logic                   req_batch_end      = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic                   rsp_has_data;
   logic [FREQ_W-1:0]      rsp_avg_mhz;
   logic [FREQ_W-1:0]      rsp_max_mhz;
   logic [FREQ_W-1:0]      rsp_min_mhz;
   logic [COUNT_OUT_W-1:0] rsp_accepted_count;

   // predictor state: mirror of the limits, the last-value table and the batch accumulators
   logic [FREQ_W-1:0]      last_value [SIGNAL_COUNT_DEF];
   bit                     seen_mark  [SIGNAL_COUNT_DEF];
   logic [FREQ_W-1:0]      lim_lo     = LOW_LIMIT_RST;
   logic [FREQ_W-1:0]      lim_hi     = HIGH_LIMIT_RST;
   logic [27:0]            acc_sum    = '0;
   logic [COUNT_OUT_W-1:0] acc_count  = '0;
   logic [FREQ_W-1:0]      acc_max    = LOW_LIMIT_RST;
   logic [FREQ_W-1:0]      acc_min    = HIGH_LIMIT_RST;

   batch_summary_type expected_summaries [$];
   sample_word_type   pending_words      [$];

   // generator's own view of the last value per signal, used to aim flat-line repeats
   logic [FREQ_W-1:0] gen_last [SIGNAL_COUNT_DEF];
   bit                gen_seen [SIGNAL_COUNT_DEF];

   int words_queued  = 0;
   int words_taken   = 0;
   int bad_words     = 0;
   int send_idle_pct = 26;
   int recv_idle_pct = 71;
   int hold_left     = 0;
   bit hold_done     = 1'b0;
   int quiet_cycles  = 0;

   frequency_batch_stats_flatline u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_signal_index   (req_signal_index),
      .req_freq_mhz       (req_freq_mhz),
      .req_batch_end      (req_batch_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_has_data       (rsp_has_data),
      .rsp_avg_mhz        (rsp_avg_mhz),
      .rsp_max_mhz        (rsp_max_mhz),
      .rsp_min_mhz        (rsp_min_mhz),
      .rsp_accepted_count (rsp_accepted_count)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // fold one accepted sample into the batch; a batch-end word queues the expected summary
   function automatic void absorb_sample(input sample_word_type w);
      batch_summary_type s;
      logic              flat;
      flat = 1'b0;
      // flat line: same value as the last one stored for this signal, entry left alone
      if (seen_mark[w.signal_index] && last_value[w.signal_index] == w.freq_mhz) begin
         flat = 1'b1;
      end else begin
         last_value[w.signal_index] = w.freq_mhz;
         seen_mark[w.signal_index]  = 1'b1;
      end
      // strict window, and nothing more once the batch is full
      if (!flat && w.freq_mhz > lim_lo && w.freq_mhz < lim_hi && acc_count < MAX_BATCH_DEF) begin
         if (acc_count == 0) begin
            // first counted sample loads both extremes directly
            acc_max = w.freq_mhz;
            acc_min = w.freq_mhz;
         end else begin
            if (w.freq_mhz > acc_max) acc_max = w.freq_mhz;
            if (w.freq_mhz < acc_min) acc_min = w.freq_mhz;
         end
         acc_sum   = acc_sum + w.freq_mhz;
         acc_count = acc_count + 1'b1;
      end
      if (w.batch_end) begin
         // empty batch reports all zero fields
         s = '0;
         if (acc_count != 0) begin
            s.has_data       = 1'b1;
            s.avg_mhz        = FREQ_W'(acc_sum / acc_count);
            s.max_mhz        = acc_max;
            s.min_mhz        = acc_min;
            s.accepted_count = acc_count;
         end
         expected_summaries.push_back(s);
         acc_sum   = '0;
         acc_count = '0;
         acc_max   = lim_lo;
         acc_min   = lim_hi;
      end
   endfunction

   function automatic string describe_summary(input batch_summary_type s);
      return $sformatf("has_data=%0d avg=%0d max=%0d min=%0d count=%0d",
                       s.has_data, s.avg_mhz, s.max_mhz, s.min_mhz, s.accepted_count);
   endfunction

   function automatic void queue_word(input logic [IDX_W-1:0] idx,
                                      input logic [FREQ_W-1:0] freq, input logic last);
      sample_word_type w;
      w = '{idx, freq, last};
      pending_words.push_back(w);
      gen_last[idx] = freq;
      gen_seen[idx] = 1'b1;
      words_queued++;
   endfunction

   // limit write; only called with the block idle
   task automatic write_limit(input csr_index_type which, input logic [FREQ_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= which;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // wait until every queued word is taken and every summary is back, then let the block finish
   task automatic settle();
      while (words_taken != words_queued || expected_summaries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly short batches over a few busy signals; the last batch may stay open
   task automatic random_run(input int n, input int lo, input int hi);
      int                left;
      int                blen;
      int                pick;
      logic [IDX_W-1:0]  idx;
      logic [FREQ_W-1:0] f;
      left = n;
      while (left > 0) begin
         blen = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         for (int i = 0; i < blen && left > 0; i++) begin
            idx  = ($urandom_range(3, 0) != 0) ? IDX_W'($urandom_range(7, 0)) : IDX_W'($urandom);
            pick = $urandom_range(99, 0);
            if (pick < 15 && gen_seen[idx]) begin
               // deliberate flat line
               f = gen_last[idx];
            end else if (pick < 60 && hi > lo + 1) begin
               f = FREQ_W'($urandom_range(hi - 1, lo + 1));
            end else if (pick < 72) begin
               // right on or just inside a limit
               case ($urandom_range(3, 0))
                  0: f = FREQ_W'(lo);
                  1: f = FREQ_W'(lo + 1);
                  2: f = FREQ_W'(hi - 1);
                  default: f = FREQ_W'(hi);
               endcase
            end else if (pick < 85) begin
               f = FREQ_W'(($urandom_range(1, 0) != 0 ? hi : lo) + $urandom_range(200, 0) - 100);
            end else begin
               f = FREQ_W'($urandom);
            end
            queue_word(idx, f, i == blen - 1);
            left--;
         end
      end
   endtask

   // driver: offers words from the pending queue, holds them while stalled
   always @(posedge clock) begin : drive_proc
      sample_word_type taken;
      sample_word_type nxt;
      // limits are only written while idle, so the mirror can follow the write directly
      if (csr_wr_en) begin
         if (csr_index == CSR_HIGH_LIMIT) lim_hi = csr_wr_data;
         else lim_lo = csr_wr_data;
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken = '{req_signal_index, req_freq_mhz, req_batch_end};
            absorb_sample(taken);
            words_taken <= words_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               nxt = pending_words.pop_front();
               req_valid        <= 1'b1;
               req_signal_index <= nxt.signal_index;
               req_freq_mhz     <= nxt.freq_mhz;
               req_batch_end    <= nxt.batch_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long hold-off on the result side once the random part is under way
   always @(posedge clock) begin : hold_proc
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && words_taken >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // receiver stall: forced high during the hold-off, random otherwise
   always @(posedge clock) begin : stall_proc
      if (hold_left != 0) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
   end

   // monitor: each accepted summary word against the oldest expectation
   always @(posedge clock) begin : check_proc
      batch_summary_type got;
      batch_summary_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_has_data, rsp_avg_mhz, rsp_max_mhz, rsp_min_mhz, rsp_accepted_count};
         if (expected_summaries.size() == 0) begin
            if (bad_words < 10) $display("unexpected summary word: %s", describe_summary(got));
            bad_words++;
         end else begin
            want = expected_summaries.pop_front();
            if (got !== want) begin
               if (bad_words < 10) begin
                  $display("summary mismatch: expected %s", describe_summary(want));
                  $display("                  actual   %s", describe_summary(got));
               end
               bad_words++;
            end
         end
      end
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin : watchdog_proc
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int lo;
      int hi;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset limits 57000 / 62000
      queue_word(0, 0, 1'b1);              // empty batch
      queue_word(1, 57000, 1'b0);          // equal to low limit, rejected
      queue_word(2, 57001, 1'b0);          // just inside low
      queue_word(3, 61999, 1'b0);          // just inside high
      queue_word(4, 62000, 1'b0);          // equal to high limit, rejected
      queue_word(5, FREQ_TOP, 1'b0);       // top of the field
      queue_word(3, 61999, 1'b0);          // flat line on signal 3
      queue_word(3, 60000, 1'b1);
      queue_word(255, 58500, 1'b1);        // single-sample batch, top index
      settle();

      // widest window
      write_limit(CSR_LOW_LIMIT, '0);
      write_limit(CSR_HIGH_LIMIT, FREQ_TOP);
      queue_word(10, 0, 1'b0);
      queue_word(11, 1, 1'b0);
      queue_word(12, FREQ_TOP - 1'b1, 1'b0);
      queue_word(13, FREQ_TOP, 1'b0);
      queue_word(255, 58500, 1'b1);        // flat line, batch ends with two counted
      settle();

      // adjacent limits: low = high - 1 lets nothing through
      write_limit(CSR_LOW_LIMIT, 100);
      write_limit(CSR_HIGH_LIMIT, 101);
      queue_word(20, 100, 1'b0);
      queue_word(21, 101, 1'b0);
      queue_word(22, 99, 1'b1);
      settle();

      // low above high
      write_limit(CSR_LOW_LIMIT, FREQ_TOP);
      write_limit(CSR_HIGH_LIMIT, '0);
      queue_word(23, 65536, 1'b1);

      // random phases; a batch may stay open across a limit change
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         case (p)
            0: begin lo = 57000; hi = 62000; end
            1: begin lo = 59950; hi = 60050; end
            2: begin
               lo = $urandom_range(120000, 0);
               hi = lo + $urandom_range(11000, 2);
            end
            3: begin lo = 60000; hi = 60002; end
            4: begin lo = 0; hi = 131071; end
            default: begin lo = 57000; hi = 62000; end
         endcase
         write_limit(CSR_LOW_LIMIT, FREQ_W'(lo));
         write_limit(CSR_HIGH_LIMIT, FREQ_W'(hi));
         // idling: slow receiver first, then slow sender, then full speed
         if (p == 2) begin
            send_idle_pct <= 71;
            recv_idle_pct <= 26;
         end else if (p == 4) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         random_run(RANDOM_WORDS, lo, hi);
      end
      queue_word(0, 60000, 1'b1);          // close whatever batch is open
      settle();

      if (bad_words == 0 && expected_summaries.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/fbs_pkg.sv
rtl/core/fbs_last_table.sv
rtl/core/fbs_divider.sv
rtl/core/frequency_batch_stats_flatline.sv
verif/frequency_batch_stats_flatline_tb.sv
